/* rtl/s2mac_pkg.sv */
// Types, constants and SHA-256 helper functions shared by the two-stage MAC unit.
package s2mac_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd3;

  localparam logic [63:0] KEY_LOW_RST   = 64'h9B55_06D1_3F43_DA94;
  localparam logic [63:0] KEY_MID_RST   = 64'hD1F2_333E_2259_FE26;
  localparam logic [31:0] KEY_HIGH_RST  = 32'h1466_3F75;
  localparam logic [63:0] DEVICE_ID_RST = 64'h0;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] LEN_WORD = 32'h0000_0180;

  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  typedef struct packed {
    logic [63:0] challenge_low;
    logic [63:0] challenge_mid;
    logic [31:0] challenge_high;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic       cap;
    logic       load;
    logic       pass;
    logic       round;
    logic [5:0] rnd;
    logic       fin;
    logic [2:0] oidx;
  } cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] sha_init(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] fixed_chal(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h29E521DF;
      3'd1: r = 32'hF9DD550E;
      3'd2: r = 32'h952BC88B;
      3'd3: r = 32'h32FF3548;
      3'd4: r = 32'hA7F8CFB7;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'h428a2f98;
      6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;
      6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;
      6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;
      6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;
      6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;
      6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;
      6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;
      6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;
      6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;
      6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;
      6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;
      6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;
      6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;
      6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;
      6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;
      6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;
      6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;
      6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;
      6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;
      6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;
      6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/s2mac_dp.sv */
// Datapath: key registers, message schedule window, round registers and digest store.
module s2mac_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [s2mac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [s2mac_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  s2mac_pkg::in_t                      in_data_i,
  input  s2mac_pkg::cmd_t                     cmd_i,
  output logic [31:0]                         digest_o
);

  logic [63:0] key_low_q;
  logic [63:0] key_mid_q;
  logic [31:0] key_high_q;
  logic [63:0] device_id_q;

  logic [31:0] chal_q [5];
  logic [31:0] w_q    [16];
  logic [31:0] v_q    [8];
  logic [31:0] h_q    [8];

  logic [31:0] blk    [16];
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] mj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q   <= s2mac_pkg::KEY_LOW_RST;
      key_mid_q   <= s2mac_pkg::KEY_MID_RST;
      key_high_q  <= s2mac_pkg::KEY_HIGH_RST;
      device_id_q <= s2mac_pkg::DEVICE_ID_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        s2mac_pkg::CFG_KEY_LOW:   key_low_q   <= cfg_data_i;
        s2mac_pkg::CFG_KEY_MID:   key_mid_q   <= cfg_data_i;
        s2mac_pkg::CFG_KEY_HIGH:  key_high_q  <= cfg_data_i[31:0];
        s2mac_pkg::CFG_DEVICE_ID: device_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cmd_i.pass) begin
      for (int i = 0; i < 5; i++) begin
        blk[i]     = chal_q[i];
        blk[5 + i] = h_q[3 + i];
      end
    end else begin
      for (int i = 0; i < 5; i++) begin
        blk[i] = s2mac_pkg::fixed_chal(3'(i));
      end
      blk[5] = key_low_q[31:0];
      blk[6] = key_low_q[63:32];
      blk[7] = key_mid_q[31:0];
      blk[8] = key_mid_q[63:32];
      blk[9] = key_high_q;
    end
    blk[10] = device_id_q[31:0];
    blk[11] = device_id_q[63:32];
    blk[12] = s2mac_pkg::PAD_WORD;
    blk[13] = 32'h0;
    blk[14] = 32'h0;
    blk[15] = s2mac_pkg::LEN_WORD;
  end

  always_comb begin
    w_new = w_q[0] + s2mac_pkg::sml_s0(w_q[1]) + w_q[9] + s2mac_pkg::sml_s1(w_q[14]);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    mj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + s2mac_pkg::big_s1(v_q[4]) + ch + s2mac_pkg::sha_k(cmd_i.rnd) + w_q[0];
    t2    = s2mac_pkg::big_s0(v_q[0]) + mj;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      chal_q[0] <= in_data_i.challenge_low[31:0];
      chal_q[1] <= in_data_i.challenge_low[63:32];
      chal_q[2] <= in_data_i.challenge_mid[31:0];
      chal_q[3] <= in_data_i.challenge_mid[63:32];
      chal_q[4] <= in_data_i.challenge_high;
    end
    if (cmd_i.load) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= blk[i];
      end
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= s2mac_pkg::sha_init(3'(i));
      end
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
      v_q[7]  <= v_q[6];
      v_q[6]  <= v_q[5];
      v_q[5]  <= v_q[4];
      v_q[4]  <= v_q[3] + t1;
      v_q[3]  <= v_q[2];
      v_q[2]  <= v_q[1];
      v_q[1]  <= v_q[0];
      v_q[0]  <= t1 + t2;
    end
    if (cmd_i.fin) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= s2mac_pkg::sha_init(3'(i)) + v_q[i];
      end
    end
  end

  assign digest_o = h_q[cmd_i.oidx];

endmodule

/* rtl/s2mac_ctrl.sv */
// Controller: sequences the two compressions and the eight output items.
module s2mac_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output s2mac_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       pass_q, pass_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] oidx_q, oidx_d;

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    rnd_d       = rnd_q;
    oidx_d      = oidx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.pass  = pass_q;
    cmd_o.rnd   = rnd_q;
    cmd_o.oidx  = oidx_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap  = 1'b1;
          cmd_o.load = 1'b1;
          cmd_o.pass = 1'b0;
          pass_d     = 1'b0;
          rnd_d      = '0;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == s2mac_pkg::LAST_ROUND) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        if (pass_q) begin
          oidx_d  = '0;
          state_d = S_OUT;
        end else begin
          pass_d  = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        rnd_d      = '0;
        state_d    = S_RUN;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == s2mac_pkg::LAST_WORD) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
      rnd_q   <= '0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
    end
  end

endmodule

/* rtl/sha256_two_stage_auth_mac_unit.sv */
// Top level of the two-stage SHA-256 challenge-response MAC unit.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (s2mac_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (s2mac_pkg::out_t)
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One item runs two passes of 64 rounds in the shared round unit, each
// followed by a finalize step, with a reload step between the passes; it
// then presents eight output items, one per cycle while out_ready_i is high.
// in_ready_o is high only while idle. Reset is asynchronous, active low, and
// restores the default key and a zero device ID. Output stalls hold the item.
module sha256_two_stage_auth_mac_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [s2mac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [s2mac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  s2mac_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output s2mac_pkg::out_t                  out_data_o
);

  s2mac_pkg::cmd_t cmd;
  logic [31:0]     digest;

  s2mac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  s2mac_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .digest_o   (digest)
  );

  assign out_data_o.digest_word = digest;
  assign out_data_o.word_index  = cmd.oidx;
  assign out_data_o.last_word   = (cmd.oidx == s2mac_pkg::LAST_WORD);

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while output items pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o))
    else $error("unit not busy after accepting an item");

  a_index_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_word) |=>
      (out_valid_o && out_data_o.word_index == 3'($past(out_data_o.word_index) + 3'd1)))
    else $error("digest word index did not advance");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_word) |=> (!out_valid_o && in_ready_o))
    else $error("unit not idle after last digest word");
`endif

endmodule
